// ----- rtl/core/wfm_pkg.sv -----
// Shared types and constants for the window frequency measurement block.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps
package wfm_pkg;

  // Field widths
  localparam int COUNT_W = 64;
  localparam int CFG_W   = 32;
  localparam int FREQ_W  = 34;

  // Quotient bits worth computing: anything at or above 2^35 is out of range
  localparam int QUOT_W      = 35;
  localparam int DIV_STEPS   = 5;
  localparam int DIV_STAGES  = QUOT_W / DIV_STEPS;
  localparam int ROUND_W     = QUOT_W + 1;

  // Accepted output range, inclusive
  localparam logic [ROUND_W-1:0] FREQ_MIN_HZ = ROUND_W'(64'd1000000);
  localparam logic [ROUND_W-1:0] FREQ_MAX_HZ = ROUND_W'(64'd10000000000);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_CLOCK_HZ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 1'b1;

  typedef struct packed {
    logic [COUNT_W-1:0] start_count;
    logic [COUNT_W-1:0] end_count;
  } in_item_t;

  typedef struct packed {
    logic              valid_res;
    logic [FREQ_W-1:0] measured_hz;
  } out_item_t;

  // Divider pipeline payload: partial remainder plus a shift register that
  // feeds dividend bits out the top and takes quotient bits in at the bottom
  typedef struct packed {
    logic              bad;
    logic [CFG_W-1:0]  rem;
    logic [QUOT_W-1:0] bits;
  } div_data_t;

endpackage

// ----- rtl/core/window_frequency_measurement.sv -----
// Window frequency measurement: (end - start) * ref_hz / ticks, rounded.
// Depends on wfm_pkg, wfm_front, wfm_div_stage, wfm_back.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries one item with the
//   counter readings at window start and end. Output channel (out_valid /
//   out_stall / out_item) returns one item per input: valid_res and
//   measured_hz, the latter zero whenever valid_res is 0.
//   Configuration: cfg_we with cfg_index 0 writes reference_clock_hz, index 1
//   writes window_ticks. Write only while no item is in flight.
//   Pipeline: 3 front stages (delta, 32x32 partial products, product
//   sum and checks), 7 divider stages of 5 quotient bits each, and 2 back
//   stages (rounding, range check into the output register).
//   Throughput is one item per cycle while out_stall is low; each stage
//   holds a valid bit and stalls only when it is full and the stage after
//   it stalls, so bubbles collapse and new items keep entering while a
//   result waits, until all 12 stages are full.
//   Reset clears all valid bits and both configuration registers; with
//   either register zero every result comes back with valid_res 0.
//   When out_stall is high the output item holds until taken.
`timescale 1ns / 1ps
module window_frequency_measurement (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  wfm_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output wfm_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [wfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wfm_pkg::CFG_W-1:0]     cfg_data
);
  import wfm_pkg::*;

  logic [CFG_W-1:0] reference_clock_hz;
  logic [CFG_W-1:0] window_ticks;

  logic      div_valid [DIV_STAGES+1];
  logic      div_stall [DIV_STAGES+1];
  div_data_t div_data  [DIV_STAGES+1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_clock_hz <= '0;
      window_ticks       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REF_CLOCK_HZ: reference_clock_hz <= cfg_data;
        REG_WINDOW_TICKS: window_ticks       <= cfg_data;
        default: ;
      endcase
    end
  end

  wfm_front u_front (
    .clk                (clk),
    .rst                (rst),
    .up_valid           (in_valid),
    .up_stall           (in_stall),
    .up_item            (in_item),
    .reference_clock_hz (reference_clock_hz),
    .window_ticks       (window_ticks),
    .dn_valid           (div_valid[0]),
    .dn_stall           (div_stall[0]),
    .dn_data            (div_data[0])
  );

  // Divider pipeline
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    wfm_div_stage u_div (
      .clk          (clk),
      .rst          (rst),
      .up_valid     (div_valid[g]),
      .up_stall     (div_stall[g]),
      .up_data      (div_data[g]),
      .window_ticks (window_ticks),
      .dn_valid     (div_valid[g+1]),
      .dn_stall     (div_stall[g+1]),
      .dn_data      (div_data[g+1])
    );
  end

  wfm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (div_valid[DIV_STAGES]),
    .up_stall     (div_stall[DIV_STAGES]),
    .up_data      (div_data[DIV_STAGES]),
    .window_ticks (window_ticks),
    .dn_valid     (out_valid),
    .dn_stall     (out_stall),
    .dn_item      (out_item)
  );

endmodule

// ----- rtl/core/wfm_front.sv -----
// Front end: counter delta, split 64x32 product, overflow and range prefilter.
// Three register stages; depends on wfm_pkg.
`timescale 1ns / 1ps
module wfm_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    up_valid,
  output logic                    up_stall,
  input  wfm_pkg::in_item_t       up_item,
  input  logic [wfm_pkg::CFG_W-1:0] reference_clock_hz,
  input  logic [wfm_pkg::CFG_W-1:0] window_ticks,
  output logic                    dn_valid,
  input  logic                    dn_stall,
  output wfm_pkg::div_data_t      dn_data
);
  import wfm_pkg::*;

  logic                 s1_valid, s2_valid, s3_valid;
  logic                 s1_stall, s2_stall, s3_stall;
  logic [COUNT_W-1:0]   s1_delta;
  logic                 s1_bad, s2_bad;
  logic [2*CFG_W-1:0]   s2_lo, s2_hi;
  div_data_t            s3_data;

  logic [2*CFG_W-1:0]   lo_c, hi_c;
  logic [3*CFG_W-1:0]   product_c;
  logic                 too_big_c;

  // Stall chain: a stage holds only when it is full and its successor holds
  assign s3_stall = s3_valid && dn_stall;
  assign s2_stall = s2_valid && s3_stall;
  assign s1_stall = s1_valid && s2_stall;
  assign up_stall = s1_stall;

  // Stage 1: delta and early rejects
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_stall) begin
      s1_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!s1_stall) begin
      s1_delta <= up_item.end_count - up_item.start_count;
      s1_bad   <= (up_item.end_count <= up_item.start_count) ||
                  (reference_clock_hz == '0) || (window_ticks == '0);
    end
  end

  // Stage 2: two 32x32 partial products
  assign lo_c = (2*CFG_W)'(s1_delta[CFG_W-1:0]) * (2*CFG_W)'(reference_clock_hz);
  assign hi_c = (2*CFG_W)'(s1_delta[COUNT_W-1:CFG_W]) * (2*CFG_W)'(reference_clock_hz);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!s2_stall) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!s2_stall) begin
      s2_lo  <= lo_c;
      s2_hi  <= hi_c;
      s2_bad <= s1_bad;
    end
  end

  // Stage 3: full product, overflow, and quotient-too-large check
  assign product_c = {s2_hi, {CFG_W{1'b0}}} + {{CFG_W{1'b0}}, s2_lo};
  // product >= window_ticks * 2^35 means the quotient is past the range
  assign too_big_c = {3'b000, product_c[COUNT_W-1:QUOT_W]} >= window_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (!s3_stall) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!s3_stall) begin
      s3_data.bad  <= s2_bad || (product_c[3*CFG_W-1:COUNT_W] != '0) || too_big_c;
      s3_data.rem  <= {3'b000, product_c[COUNT_W-1:QUOT_W]};
      s3_data.bits <= product_c[QUOT_W-1:0];
    end
  end

  assign dn_valid = s3_valid;
  assign dn_data  = s3_data;

endmodule

// ----- rtl/core/wfm_div_stage.sv -----
// One restoring divider stage: DIV_STEPS quotient bits per register stage.
// Depends on wfm_pkg.
`timescale 1ns / 1ps
module wfm_div_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      up_valid,
  output logic                      up_stall,
  input  wfm_pkg::div_data_t        up_data,
  input  logic [wfm_pkg::CFG_W-1:0] window_ticks,
  output logic                      dn_valid,
  input  logic                      dn_stall,
  output wfm_pkg::div_data_t        dn_data
);
  import wfm_pkg::*;

  logic      st_valid;
  div_data_t st_data;
  div_data_t step_c;

  assign up_stall = st_valid && dn_stall;

  // Shift-compare-subtract, one quotient bit per step
  always_comb begin
    logic [CFG_W:0] trial;
    logic           q;
    step_c = up_data;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {step_c.rem, step_c.bits[QUOT_W-1]};
      q     = trial >= {1'b0, window_ticks};
      if (q) begin
        trial = trial - {1'b0, window_ticks};
      end
      step_c.rem  = trial[CFG_W-1:0];
      step_c.bits = {step_c.bits[QUOT_W-2:0], q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (!up_stall) begin
      st_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall) begin
      st_data <= step_c;
    end
  end

  assign dn_valid = st_valid;
  assign dn_data  = st_data;

endmodule

// ----- rtl/core/wfm_back.sv -----
// Back end: round half up, range check, output register.
// Two register stages; depends on wfm_pkg.
`timescale 1ns / 1ps
module wfm_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      up_valid,
  output logic                      up_stall,
  input  wfm_pkg::div_data_t        up_data,
  input  logic [wfm_pkg::CFG_W-1:0] window_ticks,
  output logic                      dn_valid,
  input  logic                      dn_stall,
  output wfm_pkg::out_item_t        dn_item
);
  import wfm_pkg::*;

  logic               r_valid, r_stall;
  logic               r_bad;
  logic [ROUND_W-1:0] r_quot;
  logic               o_valid, o_stall;
  out_item_t          o_item;
  logic               round_up_c;
  logic               in_range_c;

  assign o_stall  = o_valid && dn_stall;
  assign r_stall  = r_valid && o_stall;
  assign up_stall = r_stall;

  // Round: remainder at or above half the divisor bumps the quotient
  assign round_up_c = {up_data.rem, 1'b0} >= {1'b0, window_ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (!r_stall) begin
      r_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!r_stall) begin
      r_bad  <= up_data.bad;
      r_quot <= {1'b0, up_data.bits} + ROUND_W'(round_up_c);
    end
  end

  // Range check and result register
  assign in_range_c = !r_bad && (r_quot >= FREQ_MIN_HZ) && (r_quot <= FREQ_MAX_HZ);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (!o_stall) begin
      o_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!o_stall) begin
      o_item.valid_res   <= in_range_c;
      o_item.measured_hz <= in_range_c ? r_quot[FREQ_W-1:0] : '0;
    end
  end

  assign dn_valid = o_valid;
  assign dn_item  = o_item;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for window_frequency_measurement.
// Depends on wfm_pkg and the RTL top; predicts each result in-line and checks in order.
`timescale 1ns / 1ps
module testbench;
  import wfm_pkg::*;

  localparam logic [63:0] RATE_LO_HZ = 64'd1_000_000;
  localparam logic [63:0] RATE_HI_HZ = 64'd10_000_000_000;
  localparam logic [63:0] COUNT_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          PIPE_DEPTH = 12;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Shadow copy of the configuration registers
  logic [31:0] ref_hz_shadow;
  logic [31:0] ticks_shadow;

  out_item_t freq_expect_q[$];
  int        fail_count;
  int        items_accepted;
  int        valid_results;
  int        reg_writes;
  bit        idle_on;
  int        hold_cycles;
  int        recv_burst;

  window_frequency_measurement u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the pipeline hangs
  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Expected result: span * ref_hz / ticks, half rounded upward, range checked
  function automatic out_item_t predict_frequency(in_item_t it);
    logic [63:0]  span;
    logic [127:0] product;
    logic [127:0] quot;
    logic [127:0] rem;
    logic [127:0] half_up;
    out_item_t    r;
    r = '0;
    if (it.end_count <= it.start_count || ref_hz_shadow == 0 || ticks_shadow == 0)
      return r;
    span    = it.end_count - it.start_count;
    product = 128'(span) * 128'(ref_hz_shadow);
    if (product > 128'(COUNT_MAX))
      return r;
    quot    = product / 128'(ticks_shadow);
    rem     = product % 128'(ticks_shadow);
    half_up = 128'(ticks_shadow >> 1) + 128'(ticks_shadow[0]);
    if (rem >= half_up) begin
      if (quot == 128'(COUNT_MAX))
        return r;
      quot = quot + 1;
    end
    if (quot < 128'(RATE_LO_HZ) || quot > 128'(RATE_HI_HZ))
      return r;
    r.valid_res   = 1'b1;
    r.measured_hz = quot[FREQ_W-1:0];
    return r;
  endfunction

  function automatic in_item_t counts(logic [63:0] start_v, logic [63:0] end_v);
    in_item_t it;
    it.start_count = start_v;
    it.end_count   = end_v;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Readings whose span gives roughly the requested rate under the current setup
  function automatic in_item_t item_for_rate(logic [63:0] rate_hz);
    logic [127:0] span;
    in_item_t     it;
    if (ref_hz_shadow == 0)
      span = 128'(rate_hz);
    else
      span = (128'(rate_hz) * 128'(ticks_shadow) + 128'(ref_hz_shadow >> 1))
             / 128'(ref_hz_shadow);
    if ($urandom_range(0, 1) == 1)
      span = span + 1;
    if (span > 128'(COUNT_MAX))
      span = 128'(COUNT_MAX);
    if (span == 0)
      span = 1;
    it.start_count = rand64();
    if (it.start_count > ~span[63:0])
      it.start_count = ~span[63:0];
    it.end_count = it.start_count + span[63:0];
    return it;
  endfunction

  function automatic logic [63:0] pick_rate();
    logic [63:0] rate;
    case ($urandom_range(0, 5))
      0, 1: rate = RATE_LO_HZ + rand64() % (RATE_HI_HZ - RATE_LO_HZ + 1);
      2:    rate = RATE_LO_HZ + $urandom_range(0, 6) - 3;
      3:    rate = RATE_HI_HZ + $urandom_range(0, 6) - 3;
      4:    rate = 64'($urandom_range(1, 999_999));
      default: rate = RATE_HI_HZ + 1 + rand64() % 64'h0000_0FFF_FFFF_FFFF;
    endcase
    return rate;
  endfunction

  // Broken or arbitrary readings
  function automatic in_item_t noise_item();
    logic [63:0] a;
    logic [63:0] b;
    a = rand64();
    b = rand64();
    case ($urandom_range(0, 3))
      0:       return counts(a, b);
      1:       return counts(a, a);
      2:       return (a > b) ? counts(a, b) : counts(b, a);
      default: return counts(a >> 8, (a >> 8) + (b >> 1));
    endcase
  endfunction

  function automatic logic [31:0] pick_reg_value();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'($urandom_range(1, 200)) * 32'd1_000_000;
      2:       return 32'($urandom_range(1, 65535));
      default: return 32'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10)
      $display("ERROR: %s", msg);
  endtask

  // Drive one item and hold it until the block takes it
  task automatic send_item(input in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (freq_expect_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_REF_CLOCK_HZ)
      ref_hz_shadow = value;
    else
      ticks_shadow = value;
    reg_writes++;
  endtask

  task automatic setup(input logic [31:0] ref_hz, input logic [31:0] ticks);
    write_reg(REG_REF_CLOCK_HZ, ref_hz);
    write_reg(REG_WINDOW_TICKS, ticks);
  endtask

  // Registers are zero out of reset: every result must be a failure
  task automatic test_reset_defaults();
    send_item(counts(64'd0, COUNT_MAX));
    send_item(counts(64'd5, 64'd5_000_005));
    send_item(counts(COUNT_MAX, 64'd0));
  endtask

  // One register zero disables the block
  task automatic test_disabled();
    write_reg(REG_REF_CLOCK_HZ, 32'd25_000_000);
    send_item(counts(64'd0, 64'd1000));
    setup(32'd0, 32'd25_000);
    send_item(counts(64'd0, 64'd1000));
  endtask

  // Range edges, counter not advancing and product overflow
  task automatic test_range_limits();
    setup(32'd25_000_000, 32'd25_000);
    send_item(counts(64'd100, 64'd1100));
    send_item(counts(64'd100, 64'd1099));
    send_item(counts(64'd0, 64'd10_000_000));
    send_item(counts(64'd0, 64'd10_000_001));
    send_item(counts(COUNT_MAX - 64'd1000, COUNT_MAX));
    send_item(counts(64'd0, COUNT_MAX));
    send_item(counts(64'd0, COUNT_MAX / 64'd25_000_000 + 64'd1));
    send_item(counts(COUNT_MAX, COUNT_MAX));
  endtask

  // Exact halves round up, below half rounds down; register extremes
  task automatic test_rounding();
    setup(32'd1, 32'd2);
    send_item(counts(64'd0, 64'd2_000_001));
    setup(32'd1, 32'd3);
    send_item(counts(64'd7, 64'd3_000_008));
    send_item(counts(64'd7, 64'd3_000_009));
    setup(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(counts(64'd0, 64'd1_000_000));
    send_item(counts(64'd0, 64'd10_000_000_001));
    setup(32'hFFFF_FFFF, 32'd1);
    send_item(counts(64'd9, 64'd10));
    send_item(counts(64'd9, 64'd12));
    send_item(counts(64'd0, COUNT_MAX / 64'hFFFF_FFFF));
    setup(32'd1, 32'd1);
    send_item(counts(64'd1, 64'd10_000_000_001));
  endtask

  // Mostly plausible readings with random content, some noise, under random setups
  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      setup(pick_reg_value(), pick_reg_value());
      for (int n = 0; n < 75; n++) begin
        if (n % 25 == 0)
          idle_on = ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 4) == 0)
          send_item(noise_item());
        else
          send_item(item_for_rate(pick_rate()));
      end
    end
    idle_on = 1'b1;
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall its input
  task automatic test_long_hold();
    setup(32'd100_000_000, 32'd100_000);
    idle_on     = 1'b0;
    hold_cycles = 150;
    for (int n = 0; n < 60; n++)
      send_item(item_for_rate(pick_rate()));
    wait_drained();
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_full_rate();
    idle_on = 1'b0;
    setup(32'd19_200_000, 32'd19_200);
    for (int n = 0; n < 40; n++)
      send_item($urandom_range(0, 4) == 0 ? noise_item() : item_for_rate(pick_rate()));
  endtask

  // Record an expectation for each accepted item
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      freq_expect_q.push_back(predict_frequency(in_item));
      items_accepted++;
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (freq_expect_q.size() == 0) begin
        note_failure($sformatf("unexpected result valid_res=%0d measured_hz=%0d",
                               out_item.valid_res, out_item.measured_hz));
      end else begin
        want = freq_expect_q.pop_front();
        if (want.valid_res) valid_results++;
        if (out_item.valid_res !== want.valid_res ||
            out_item.measured_hz !== want.measured_hz)
          note_failure($sformatf("expected valid_res=%0d measured_hz=%0d, got %0d / %0d",
                                 want.valid_res, want.measured_hz,
                                 out_item.valid_res, out_item.measured_hz));
      end
    end
  end

  // Receiver stall: a requested long hold, else random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      recv_burst <= 0;
    end else if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (recv_burst > 0) begin
      out_stall  <= 1'b1;
      recv_burst <= recv_burst - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      recv_burst <= $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_item        = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    ref_hz_shadow  = '0;
    ticks_shadow   = '0;
    fail_count     = 0;
    items_accepted = 0;
    valid_results  = 0;
    reg_writes     = 0;
    idle_on        = 1'b1;
    hold_cycles    = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_disabled();
    test_range_limits();
    test_rounding();
    test_random_traffic();
    test_long_hold();
    test_full_rate();

    wait_drained();
    repeat (PIPE_DEPTH * 2) @(posedge clk);
    if (freq_expect_q.size() != 0)
      note_failure($sformatf("%0d results never arrived", freq_expect_q.size()));

    $display("Run covered %0d measurements (%0d in range) over %0d register writes,",
             items_accepted, valid_results, reg_writes);
    $display("including disabled setups, range edges, rounding halves and overflow.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
